### src/stqs_pkg.sv
`timescale 1ns / 1ps

package stqs_pkg;

  localparam int QUEUE_SLOTS_DEF = 16;
  localparam int CLIENT_BITS_DEF = 4;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 16;
  localparam int BAUD_W  = 3;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SPEED = 1'd1;

  localparam logic [TIME_W-1:0] MAX_TIME_RESET = 32'd10000;
  localparam logic [BAUD_W-1:0] BAUD_CODE_MAX  = 3'd7;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DONE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_END,
    ST_START
  } state_t;

endpackage

### src/stqs_ram.sv
`timescale 1ns / 1ps

module stqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/spi_transaction_queue_scheduler.sv
`timescale 1ns / 1ps

// FIFO scheduler for one SPI bus. An item is taken when start is high and busy is low; busy
// then stays high through ST_CMD, ST_END and ST_START, which follow the walk through the
// slot memory (write the head slot, read the tail slot, read the slot to launch). An item
// gives up to three results, in the order drop, then complete or timeout abort, then start;
// each shows on the out_ ports for exactly one cycle with out_valid high, and the last one
// of the item carries out_last. The drop shows while the state is ST_END, the complete or
// timeout abort in ST_START and the start once back in ST_IDLE; results cannot be held
// off. Configuration writes take effect at once and are meant for times when busy is low.
// The slot memory needs no clearing after reset.
module spi_transaction_queue_scheduler #(
  parameter int QUEUE_SLOTS = stqs_pkg::QUEUE_SLOTS_DEF,
  parameter int CLIENT_BITS = stqs_pkg::CLIENT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [stqs_pkg::CMD_W-1:0]          in_command,
  input  logic [CLIENT_BITS-1:0]              in_client_id,
  input  logic [stqs_pkg::ADDR_W-1:0]         in_rx_addr,
  input  logic [stqs_pkg::ADDR_W-1:0]         in_tx_addr,
  input  logic [stqs_pkg::COUNT_W-1:0]        in_byte_count,
  input  logic [stqs_pkg::BAUD_W-1:0]         in_baud_code,
  input  logic [stqs_pkg::TIME_W-1:0]         in_now_us,
  input  logic                                cfg_we,
  input  logic [stqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stqs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic [stqs_pkg::KIND_W-1:0]         out_kind,
  output logic [CLIENT_BITS-1:0]              out_client,
  output logic [stqs_pkg::ADDR_W-1:0]         out_rx_addr,
  output logic [stqs_pkg::ADDR_W-1:0]         out_tx_addr,
  output logic [stqs_pkg::COUNT_W-1:0]        out_count,
  output logic [stqs_pkg::BAUD_W-1:0]         out_baud,
  output logic [stqs_pkg::TIME_W-1:0]         out_stamp_us,
  output logic [stqs_pkg::TIME_W-1:0]         out_timeout_total,
  output logic [stqs_pkg::TIME_W-1:0]         out_longest_us,
  output logic                                out_last
);

  localparam int IDX_W  = $clog2(QUEUE_SLOTS);
  localparam int SLOT_W = CLIENT_BITS + 2 * stqs_pkg::ADDR_W + stqs_pkg::COUNT_W
                          + stqs_pkg::BAUD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  stqs_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [IDX_W-1:0]                tail_r, tail_nxt;
  logic                            active_r, active_nxt;
  logic [stqs_pkg::TIME_W-1:0]     start_time_r, start_time_nxt;
  logic [stqs_pkg::TIME_W-1:0]     timeout_count_r, timeout_count_nxt;
  logic [stqs_pkg::TIME_W-1:0]     max_time_r, max_time_nxt;
  logic [stqs_pkg::TIME_W-1:0]     max_xfer_r, max_xfer_nxt;
  logic                            dbl_r, dbl_nxt;
  logic                            ev_end_r, ev_end_nxt;
  logic                            ev_abort_r, ev_abort_nxt;
  logic                            ev_start_r, ev_start_nxt;

  logic [stqs_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [CLIENT_BITS-1:0]          client_r, client_nxt;
  logic [stqs_pkg::ADDR_W-1:0]     rx_r, rx_nxt;
  logic [stqs_pkg::ADDR_W-1:0]     tx_r, tx_nxt;
  logic [stqs_pkg::COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [stqs_pkg::BAUD_W-1:0]     baud_r, baud_nxt;
  logic [stqs_pkg::TIME_W-1:0]     now_r, now_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [stqs_pkg::KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [CLIENT_BITS-1:0]          out_client_r, out_client_nxt;
  logic [stqs_pkg::ADDR_W-1:0]     out_rx_r, out_rx_nxt;
  logic [stqs_pkg::ADDR_W-1:0]     out_tx_r, out_tx_nxt;
  logic [stqs_pkg::COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [stqs_pkg::BAUD_W-1:0]     out_baud_r, out_baud_nxt;
  logic [stqs_pkg::TIME_W-1:0]     out_stamp_r, out_stamp_nxt;
  logic [stqs_pkg::TIME_W-1:0]     out_tmo_r, out_tmo_nxt;
  logic [stqs_pkg::TIME_W-1:0]     out_long_r, out_long_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            ram_we;
  logic [SLOT_W-1:0]               ram_wdata;
  logic [SLOT_W-1:0]               ram_rdata;

  logic                            cmd_ok;
  logic                            full;
  logic                            do_drop;
  logic                            do_wr;
  logic                            do_cmpl;
  logic                            still_active;
  logic [stqs_pkg::TIME_W-1:0]     age;
  logic                            do_abort;
  logic [IDX_W-1:0]                tail_a;
  logic [IDX_W-1:0]                head_a;
  logic                            do_start;
  logic [stqs_pkg::BAUD_W-1:0]     wr_baud;

  logic [CLIENT_BITS-1:0]          rd_client;
  logic [stqs_pkg::ADDR_W-1:0]     rd_rx;
  logic [stqs_pkg::ADDR_W-1:0]     rd_tx;
  logic [stqs_pkg::COUNT_W-1:0]    rd_cnt;
  logic [stqs_pkg::BAUD_W-1:0]     rd_baud;

  stqs_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head_r),
    .wdata(ram_wdata),
    .raddr(tail_r),
    .rdata(ram_rdata)
  );

  // decisions for the latched item, evaluated in the command cycle
  assign cmd_ok       = (cmd_r != stqs_pkg::CMD_NONE);
  assign full         = (next_idx(head_r) == tail_r);
  assign do_drop      = (cmd_r == stqs_pkg::CMD_ENQUEUE) && full;
  assign do_wr        = (cmd_r == stqs_pkg::CMD_ENQUEUE) && !full;
  assign do_cmpl      = (cmd_r == stqs_pkg::CMD_DONE) && active_r;
  assign still_active = active_r && !do_cmpl;
  assign age          = now_r - start_time_r;
  assign do_abort     = cmd_ok && still_active && (age > max_xfer_r);
  assign tail_a       = (do_cmpl || do_abort) ? next_idx(tail_r) : tail_r;
  assign head_a       = do_wr ? next_idx(head_r) : head_r;
  assign do_start     = cmd_ok && (!still_active || do_abort) && (tail_a != head_a);

  assign wr_baud   = (dbl_r && (baud_r != stqs_pkg::BAUD_CODE_MAX)) ? baud_r + 1'b1 : baud_r;
  assign ram_wdata = {client_r, rx_r, tx_r, cnt_r, wr_baud};
  assign {rd_client, rd_rx, rd_tx, rd_cnt, rd_baud} = ram_rdata;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stqs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = stqs_pkg::ST_CMD;
        end
      end
      stqs_pkg::ST_CMD:   state_nxt = stqs_pkg::ST_END;
      stqs_pkg::ST_END:   state_nxt = stqs_pkg::ST_START;
      stqs_pkg::ST_START: state_nxt = stqs_pkg::ST_IDLE;
      default:            state_nxt = stqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    active_nxt        = active_r;
    start_time_nxt    = start_time_r;
    timeout_count_nxt = timeout_count_r;
    max_time_nxt      = max_time_r;
    max_xfer_nxt      = max_xfer_r;
    dbl_nxt           = dbl_r;
    ev_end_nxt        = ev_end_r;
    ev_abort_nxt      = ev_abort_r;
    ev_start_nxt      = ev_start_r;
    cmd_nxt           = cmd_r;
    client_nxt        = client_r;
    rx_nxt            = rx_r;
    tx_nxt            = tx_r;
    cnt_nxt           = cnt_r;
    baud_nxt          = baud_r;
    now_nxt           = now_r;
    ram_we            = 1'b0;
    out_valid_nxt     = 1'b0;
    out_kind_nxt      = stqs_pkg::KIND_START;
    out_client_nxt    = '0;
    out_rx_nxt        = '0;
    out_tx_nxt        = '0;
    out_cnt_nxt       = '0;
    out_baud_nxt      = '0;
    out_stamp_nxt     = '0;
    out_tmo_nxt       = timeout_count_r;
    out_long_nxt      = max_time_r;
    out_last_nxt      = 1'b0;

    if (cfg_we) begin
      if (cfg_index == stqs_pkg::CFG_MAX_TIME) begin
        max_xfer_nxt = cfg_data[stqs_pkg::TIME_W-1:0];
      end else if (cfg_index == stqs_pkg::CFG_DOUBLE_SPEED) begin
        dbl_nxt = cfg_data[0];
      end
    end

    unique case (state_r)
      stqs_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          client_nxt = in_client_id;
          rx_nxt     = in_rx_addr;
          tx_nxt     = in_tx_addr;
          cnt_nxt    = in_byte_count;
          baud_nxt   = in_baud_code;
          now_nxt    = in_now_us;
        end
      end
      stqs_pkg::ST_CMD: begin
        ram_we       = do_wr;
        head_nxt     = head_a;
        tail_nxt     = tail_a;
        active_nxt   = do_start || (still_active && !do_abort);
        ev_end_nxt   = do_cmpl || do_abort;
        ev_abort_nxt = do_abort;
        ev_start_nxt = do_start;
        if (do_start) begin
          start_time_nxt = now_r;
        end
        if (do_abort) begin
          timeout_count_nxt = timeout_count_r + 1'b1;
        end
        if (do_cmpl && (age > max_time_r)) begin
          max_time_nxt = age;
        end
        if (do_drop) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = stqs_pkg::KIND_DROP;
          out_client_nxt = client_r;
          out_last_nxt   = !(do_cmpl || do_abort || do_start);
        end
      end
      stqs_pkg::ST_END: begin
        if (ev_end_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ev_abort_r ? stqs_pkg::KIND_TIMEOUT : stqs_pkg::KIND_COMPLETE;
          out_client_nxt = rd_client;
          out_stamp_nxt  = ev_abort_r ? '0 : now_r;
          out_last_nxt   = !ev_start_r;
        end
      end
      stqs_pkg::ST_START: begin
        if (ev_start_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = stqs_pkg::KIND_START;
          out_client_nxt = rd_client;
          out_rx_nxt     = rd_rx;
          out_tx_nxt     = rd_tx;
          out_cnt_nxt    = rd_cnt;
          out_baud_nxt   = rd_baud;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= stqs_pkg::ST_IDLE;
      head_r          <= '0;
      tail_r          <= '0;
      active_r        <= 1'b0;
      start_time_r    <= '0;
      timeout_count_r <= '0;
      max_time_r      <= '0;
      max_xfer_r      <= stqs_pkg::MAX_TIME_RESET;
      dbl_r           <= 1'b0;
      ev_end_r        <= 1'b0;
      ev_abort_r      <= 1'b0;
      ev_start_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      active_r        <= active_nxt;
      start_time_r    <= start_time_nxt;
      timeout_count_r <= timeout_count_nxt;
      max_time_r      <= max_time_nxt;
      max_xfer_r      <= max_xfer_nxt;
      dbl_r           <= dbl_nxt;
      ev_end_r        <= ev_end_nxt;
      ev_abort_r      <= ev_abort_nxt;
      ev_start_r      <= ev_start_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    client_r     <= client_nxt;
    rx_r         <= rx_nxt;
    tx_r         <= tx_nxt;
    cnt_r        <= cnt_nxt;
    baud_r       <= baud_nxt;
    now_r        <= now_nxt;
    out_kind_r   <= out_kind_nxt;
    out_client_r <= out_client_nxt;
    out_rx_r     <= out_rx_nxt;
    out_tx_r     <= out_tx_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_baud_r   <= out_baud_nxt;
    out_stamp_r  <= out_stamp_nxt;
    out_tmo_r    <= out_tmo_nxt;
    out_long_r   <= out_long_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = (state_r != stqs_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_client        = out_client_r;
  assign out_rx_addr       = out_rx_r;
  assign out_tx_addr       = out_tx_r;
  assign out_count         = out_cnt_r;
  assign out_baud          = out_baud_r;
  assign out_stamp_us      = out_stamp_r;
  assign out_timeout_total = out_tmo_r;
  assign out_longest_us    = out_long_r;
  assign out_last          = out_last_r;

endmodule

### src/stqs_checker.sv
`timescale 1ns / 1ps

module stqs_props (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [stqs_pkg::KIND_W-1:0]     out_kind,
  input logic [stqs_pkg::ADDR_W-1:0]     out_rx_addr,
  input logic [stqs_pkg::ADDR_W-1:0]     out_tx_addr,
  input logic [stqs_pkg::COUNT_W-1:0]    out_count,
  input logic [stqs_pkg::BAUD_W-1:0]     out_baud,
  input logic [stqs_pkg::TIME_W-1:0]     out_stamp_us,
  input logic                            out_last
);

  // reset leaves no transfer in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("output strobe or busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a start is always the final result of its item
  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == stqs_pkg::KIND_START) |-> out_last)
    else $error("start result not marked last");

  a_slot_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != stqs_pkg::KIND_START) |->
      (out_rx_addr == '0) && (out_tx_addr == '0) && (out_count == '0) && (out_baud == '0))
    else $error("slot fields nonzero on a non-start result");

  a_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != stqs_pkg::KIND_COMPLETE) |-> (out_stamp_us == '0))
    else $error("stamp nonzero on a non-complete result");

endmodule

bind spi_transaction_queue_scheduler stqs_props u_stqs_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_kind    (out_kind),
  .out_rx_addr (out_rx_addr),
  .out_tx_addr (out_tx_addr),
  .out_count   (out_count),
  .out_baud    (out_baud),
  .out_stamp_us(out_stamp_us),
  .out_last    (out_last)
);

### bench/stqs_checker.sv
`timescale 1ns / 1ps

module stqs_checker
  import stqs_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int CLIENT_BITS = CLIENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [CLIENT_BITS-1:0] in_client_id,
  input  logic [ADDR_W-1:0]      in_rx_addr,
  input  logic [ADDR_W-1:0]      in_tx_addr,
  input  logic [COUNT_W-1:0]     in_byte_count,
  input  logic [BAUD_W-1:0]      in_baud_code,
  input  logic [TIME_W-1:0]      in_now_us,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   out_valid,
  input  logic [KIND_W-1:0]      out_kind,
  input  logic [CLIENT_BITS-1:0] out_client,
  input  logic [ADDR_W-1:0]      out_rx_addr,
  input  logic [ADDR_W-1:0]      out_tx_addr,
  input  logic [COUNT_W-1:0]     out_count,
  input  logic [BAUD_W-1:0]      out_baud,
  input  logic [TIME_W-1:0]      out_stamp_us,
  input  logic [TIME_W-1:0]      out_timeout_total,
  input  logic [TIME_W-1:0]      out_longest_us,
  input  logic                   out_last,
  output int                     mismatches,
  output int                     pending,
  output int                     n_commands,
  output int                     n_starts,
  output int                     n_completes,
  output int                     n_aborts,
  output int                     n_drops
);

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [CLIENT_BITS-1:0] client;
    logic [ADDR_W-1:0]      rx_addr;
    logic [ADDR_W-1:0]      tx_addr;
    logic [COUNT_W-1:0]     count;
    logic [BAUD_W-1:0]      baud;
    logic [TIME_W-1:0]      stamp;
    logic [TIME_W-1:0]      timeout_total;
    logic [TIME_W-1:0]      longest;
    logic                   last;
  } sched_event_t;

  logic [CLIENT_BITS-1:0] ring_client [QUEUE_SLOTS];
  logic [ADDR_W-1:0]      ring_rx     [QUEUE_SLOTS];
  logic [ADDR_W-1:0]      ring_tx     [QUEUE_SLOTS];
  logic [COUNT_W-1:0]     ring_count  [QUEUE_SLOTS];
  logic [BAUD_W-1:0]      ring_baud   [QUEUE_SLOTS];
  int                     head_slot;
  int                     tail_slot;
  logic                   bus_running;
  logic [TIME_W-1:0]      launch_time;
  logic [TIME_W-1:0]      abort_total;
  logic [TIME_W-1:0]      longest_time;
  logic [TIME_W-1:0]      limit_us;
  logic                   double_speed;

  sched_event_t expected_events[$];
  sched_event_t oldest;

  function automatic sched_event_t make_event(
    input logic [KIND_W-1:0] kind, input logic [CLIENT_BITS-1:0] client,
    input logic [ADDR_W-1:0] rx, input logic [ADDR_W-1:0] tx,
    input logic [COUNT_W-1:0] cnt, input logic [BAUD_W-1:0] code,
    input logic [TIME_W-1:0] stamp);
    sched_event_t ev;
    ev.kind          = kind;
    ev.client        = client;
    ev.rx_addr       = rx;
    ev.tx_addr       = tx;
    ev.count         = cnt;
    ev.baud          = code;
    ev.stamp         = stamp;
    ev.timeout_total = abort_total;
    ev.longest       = longest_time;
    ev.last          = 1'b0;
    return ev;
  endfunction

  // queue update and launch attempt for one accepted command
  task automatic schedule_item(
    input logic [CMD_W-1:0] cmd, input logic [CLIENT_BITS-1:0] client,
    input logic [ADDR_W-1:0] rx, input logic [ADDR_W-1:0] tx,
    input logic [COUNT_W-1:0] cnt, input logic [BAUD_W-1:0] baud,
    input logic [TIME_W-1:0] now);
    sched_event_t      batch[$];
    logic [BAUD_W-1:0] code;
    logic [TIME_W-1:0] age;
    int                t;
    if (cmd == CMD_NONE) return;
    n_commands++;
    if (cmd == CMD_ENQUEUE) begin
      if ((head_slot + 1) % QUEUE_SLOTS == tail_slot) begin
        batch.push_back(make_event(KIND_DROP, client, '0, '0, '0, '0, '0));
      end else begin
        code = baud;
        if (double_speed && code != BAUD_CODE_MAX) code = code + 1'b1;
        ring_client[head_slot] = client;
        ring_rx[head_slot]     = rx;
        ring_tx[head_slot]     = tx;
        ring_count[head_slot]  = cnt;
        ring_baud[head_slot]   = code;
        head_slot = (head_slot + 1) % QUEUE_SLOTS;
      end
    end else if (cmd == CMD_DONE && bus_running) begin
      t = tail_slot;
      age = now - launch_time;
      if (age > longest_time) longest_time = age;
      bus_running = 1'b0;
      tail_slot = (t + 1) % QUEUE_SLOTS;
      batch.push_back(make_event(KIND_COMPLETE, ring_client[t], '0, '0, '0, '0, now));
    end
    age = now - launch_time;
    if (bus_running && age > limit_us) begin
      t = tail_slot;
      abort_total = abort_total + 1'b1;
      bus_running = 1'b0;
      tail_slot = (t + 1) % QUEUE_SLOTS;
      batch.push_back(make_event(KIND_TIMEOUT, ring_client[t], '0, '0, '0, '0, '0));
    end
    if (!bus_running && tail_slot != head_slot) begin
      t = tail_slot;
      bus_running = 1'b1;
      launch_time = now;
      batch.push_back(make_event(KIND_START, ring_client[t], ring_rx[t], ring_tx[t],
                                 ring_count[t], ring_baud[t], '0));
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) begin
      case (batch[i].kind)
        KIND_START:    n_starts++;
        KIND_COMPLETE: n_completes++;
        KIND_TIMEOUT:  n_aborts++;
        default:       n_drops++;
      endcase
      expected_events.push_back(batch[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot    = 0;
      tail_slot    = 0;
      bus_running  = 1'b0;
      launch_time  = '0;
      abort_total  = '0;
      longest_time = '0;
      limit_us     = MAX_TIME_RESET;
      double_speed = 1'b0;
      mismatches   = 0;
      n_commands   = 0;
      n_starts     = 0;
      n_completes  = 0;
      n_aborts     = 0;
      n_drops      = 0;
      expected_events.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_events.size() == 0) begin
          $display("%0t: expected no event, got kind %0d client %0h", $time, out_kind,
                   out_client);
          mismatches++;
        end else begin
          oldest = expected_events.pop_front();
          compare_field("kind", 32'(oldest.kind), 32'(out_kind));
          compare_field("client", 32'(oldest.client), 32'(out_client));
          compare_field("rx_addr", oldest.rx_addr, out_rx_addr);
          compare_field("tx_addr", oldest.tx_addr, out_tx_addr);
          compare_field("count", 32'(oldest.count), 32'(out_count));
          compare_field("baud", 32'(oldest.baud), 32'(out_baud));
          compare_field("stamp_us", oldest.stamp, out_stamp_us);
          compare_field("timeout_total", oldest.timeout_total, out_timeout_total);
          compare_field("longest_us", oldest.longest, out_longest_us);
          compare_field("last", 32'(oldest.last), 32'(out_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_TIME:     limit_us = cfg_data;
          CFG_DOUBLE_SPEED: double_speed = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        schedule_item(in_command, in_client_id, in_rx_addr, in_tx_addr, in_byte_count,
                      in_baud_code, in_now_us);
      end
      pending <= expected_events.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import stqs_pkg::*;

  localparam int MAX_CYCLES = 200000;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [CMD_W-1:0]           in_command = CMD_NONE;
  logic [CLIENT_BITS_DEF-1:0] in_client_id = '0;
  logic [ADDR_W-1:0]          in_rx_addr = '0;
  logic [ADDR_W-1:0]          in_tx_addr = '0;
  logic [COUNT_W-1:0]         in_byte_count = '0;
  logic [BAUD_W-1:0]          in_baud_code = '0;
  logic [TIME_W-1:0]          in_now_us = '0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       out_valid;
  logic [KIND_W-1:0]          out_kind;
  logic [CLIENT_BITS_DEF-1:0] out_client;
  logic [ADDR_W-1:0]          out_rx_addr;
  logic [ADDR_W-1:0]          out_tx_addr;
  logic [COUNT_W-1:0]         out_count;
  logic [BAUD_W-1:0]          out_baud;
  logic [TIME_W-1:0]          out_stamp_us;
  logic [TIME_W-1:0]          out_timeout_total;
  logic [TIME_W-1:0]          out_longest_us;
  logic                       out_last;

  int mismatches;
  int pending;
  int n_commands;
  int n_starts;
  int n_completes;
  int n_aborts;
  int n_drops;

  int                cycles = 0;
  int                quiet_run = 0;
  logic [TIME_W-1:0] bus_time = '0;
  logic [TIME_W-1:0] limit_now = MAX_TIME_RESET;

  spi_transaction_queue_scheduler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_client_id      (in_client_id),
    .in_rx_addr        (in_rx_addr),
    .in_tx_addr        (in_tx_addr),
    .in_byte_count     (in_byte_count),
    .in_baud_code      (in_baud_code),
    .in_now_us         (in_now_us),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_client        (out_client),
    .out_rx_addr       (out_rx_addr),
    .out_tx_addr       (out_tx_addr),
    .out_count         (out_count),
    .out_baud          (out_baud),
    .out_stamp_us      (out_stamp_us),
    .out_timeout_total (out_timeout_total),
    .out_longest_us    (out_longest_us),
    .out_last          (out_last)
  );

  stqs_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_client_id      (in_client_id),
    .in_rx_addr        (in_rx_addr),
    .in_tx_addr        (in_tx_addr),
    .in_byte_count     (in_byte_count),
    .in_baud_code      (in_baud_code),
    .in_now_us         (in_now_us),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_client        (out_client),
    .out_rx_addr       (out_rx_addr),
    .out_tx_addr       (out_tx_addr),
    .out_count         (out_count),
    .out_baud          (out_baud),
    .out_stamp_us      (out_stamp_us),
    .out_timeout_total (out_timeout_total),
    .out_longest_us    (out_longest_us),
    .out_last          (out_last),
    .mismatches        (mismatches),
    .pending           (pending),
    .n_commands        (n_commands),
    .n_starts          (n_starts),
    .n_completes       (n_completes),
    .n_aborts          (n_aborts),
    .n_drops           (n_drops)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // idle cycles before a transfer, with occasional back-to-back stretches
  function automatic int draw_gap();
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(19, 0) == 0) quiet_run = $urandom_range(20, 5);
    return $urandom_range(16, 0);
  endfunction

  task automatic issue(
    input logic [CMD_W-1:0] cmd, input logic [CLIENT_BITS_DEF-1:0] client,
    input logic [ADDR_W-1:0] rx, input logic [ADDR_W-1:0] tx,
    input logic [COUNT_W-1:0] cnt, input logic [BAUD_W-1:0] code,
    input logic [TIME_W-1:0] at_us);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_client_id  <= client;
    in_rx_addr    <= rx;
    in_tx_addr    <= tx;
    in_byte_count <= cnt;
    in_baud_code  <= code;
    in_now_us     <= at_us;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int items, input logic [TIME_W-1:0] limit,
                           input logic ds);
    int                sent;
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] span;
    settle();
    write_reg(CFG_MAX_TIME, limit);
    write_reg(CFG_DOUBLE_SPEED, {{(CFG_DATA_W-1){1'b0}}, ds});
    limit_now = limit;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) cmd = CMD_ENQUEUE;
      else if (pick < 70) cmd = CMD_DONE;
      else if (pick < 95) cmd = CMD_POLL;
      else cmd = CMD_NONE;
      // time mostly moves around the timeout, now and then jumps anywhere
      if ($urandom_range(7, 0) == 0) begin
        bus_time = bus_time + $urandom;
      end else begin
        span = (limit_now < 30000) ? limit_now * 2 + 2 : 30000;
        bus_time = bus_time + $urandom_range(span, 0);
      end
      issue(cmd, CLIENT_BITS_DEF'($urandom_range(15, 0)), $urandom, $urandom,
            COUNT_W'($urandom_range(65535, 0)), BAUD_W'($urandom_range(7, 0)), bus_time);
      sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, done while idle, unused command
    issue(CMD_POLL, 4'h0, '0, '0, '0, '0, 32'd0);
    issue(CMD_DONE, 4'h0, '0, '0, '0, '0, 32'd5);
    issue(CMD_NONE, 4'hF, $urandom, $urandom, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    // field extremes, then fill the ring
    issue(CMD_ENQUEUE, 4'hF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 3'd7, 32'd10);
    issue(CMD_ENQUEUE, 4'h0, 32'h0, 32'hFFFF_FFFF, 16'h0, 3'd0, 32'd20);
    repeat (13) begin
      issue(CMD_ENQUEUE, CLIENT_BITS_DEF'($urandom_range(15, 0)), $urandom, $urandom,
            COUNT_W'($urandom_range(65535, 0)), BAUD_W'($urandom_range(7, 0)), 32'd30);
    end
    // full ring: drop at exactly the limit, then drop with abort and launch
    issue(CMD_ENQUEUE, 4'h5, $urandom, $urandom, 16'h1234, 3'd3, 32'd10010);
    issue(CMD_ENQUEUE, 4'hA, $urandom, $urandom, 16'h4321, 3'd4, 32'd10011);
    issue(CMD_POLL, 4'h0, '0, '0, '0, '0, 32'd20011);
    // longest time grows, then is kept
    issue(CMD_DONE, 4'h0, '0, '0, '0, '0, 32'd20500);
    issue(CMD_DONE, 4'h0, '0, '0, '0, '0, 32'd20600);
    bus_time = 32'd20600;

    run_phase(87, 32'hFFFF_FFFF, 1'b1);
    run_phase(87, 32'd0, 1'b0);
    bus_time = 32'hFFFF_FF00;
    run_phase(87, 32'd50, 1'b1);
    run_phase(87, $urandom_range(20000, 100), 1'($urandom_range(1, 0)));
    run_phase(87, MAX_TIME_RESET, 1'b0);

    settle();
    $display("covered %0d scheduling commands under five timeout and bus speed settings",
             n_commands);
    $display("events: %0d starts, %0d completions, %0d timeout aborts, %0d drops",
             n_starts, n_completes, n_aborts, n_drops);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
